[design/ipft_pkg.sv]
// Package for the IP five-tuple extractor: packet kinds, outcome codes,
// protocol and header constants, and the result record.
// Used by ipft_parser and ip_five_tuple_extractor_top; depends on nothing.
`default_nettype none

package ipft_pkg;

  localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [6:0] V4_HDR_LEN = 7'd20;
  localparam logic [6:0] V6_HDR_LEN = 7'd40;
  localparam logic [6:0] OFFSET_MAX = 7'd127;
  localparam logic [2:0] PORT_BYTES = 3'd4;

  localparam logic [3:0] IP_VER_4 = 4'd4;
  localparam logic [3:0] IP_VER_6 = 4'd6;

  localparam logic [2:0] FAMILY_NONE = 3'd0;
  localparam logic [2:0] FAMILY_V4   = 3'd4;
  localparam logic [2:0] FAMILY_V6   = 3'd6;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_IDX_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_V4    = 2'd1,
    KIND_V6    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OUT_TUPLE     = 2'd0,
    OUT_NO_HEADER = 2'd1,
    OUT_NO_TUPLE  = 2'd2,
    OUT_TRUNCATED = 2'd3
  } outcome_e;

  typedef struct packed {
    outcome_e     outcome;
    logic [2:0]   family;
    logic [7:0]   protocol;
    logic [127:0] src_addr;
    logic [127:0] dst_addr;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
  } result_t;

endpackage

`default_nettype wire

[design/ip_five_tuple_extractor_top.sv]
// Top level of the IP five-tuple extractor: byte input channel, result output
// register, and the APB enable register. Depends on ipft_pkg and ipft_parser.
//
//   Channel   Handshake          Payload
//   input     in_valid/in_ready  data_byte, first/last_of_packet, ethertype, header_unset
//   output    out_valid/ready    outcome, family, protocol, addresses, ports
//   config    APB write/read     enable at byte address 0
//
// Every byte is parsed in the cycle it is transferred, one byte per cycle.
// The result of a packet's last byte is valid the next cycle in the output register.
// A byte is taken whenever the output register is empty or being drained that cycle.
// Reset empties the output register, clears the packet state and sets enable.
`default_nettype none

module ip_five_tuple_extractor_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [7:0]                     data_byte_i,
  input  wire logic                           first_of_packet_i,
  input  wire logic                           last_of_packet_i,
  input  wire logic [15:0]                    ethertype_i,
  input  wire logic                           header_unset_i,

  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic [1:0]                     outcome_o,
  output      logic [2:0]                     family_o,
  output      logic [7:0]                     protocol_o,
  output      logic [63:0]                    source_high_o,
  output      logic [63:0]                    source_low_o,
  output      logic [63:0]                    dest_high_o,
  output      logic [63:0]                    dest_low_o,
  output      logic [15:0]                    source_port_o,
  output      logic [15:0]                    dest_port_o,

  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ipft_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output      logic [31:0]                    prdata,
  output      logic                           pready
);

  logic              enable_q;
  logic              out_valid_q;
  ipft_pkg::result_t result_q;
  ipft_pkg::result_t result_d;
  logic              take;
  logic              cfg_wr;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready &&
                      (paddr[2] == ipft_pkg::REG_IDX_ENABLE);
  assign prdata     = (paddr[2] == ipft_pkg::REG_IDX_ENABLE) ? {31'd0, enable_q} : 32'd0;

  ipft_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .data_byte_i    (data_byte_i),
    .first_i        (first_of_packet_i),
    .last_i         (last_of_packet_i),
    .ethertype_i    (ethertype_i),
    .header_unset_i (header_unset_i),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_wr) begin
      enable_q <= pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && last_of_packet_i && enable_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_of_packet_i && enable_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = result_q.outcome;
  assign family_o      = result_q.family;
  assign protocol_o    = result_q.protocol;
  assign source_high_o = result_q.src_addr[127:64];
  assign source_low_o  = result_q.src_addr[63:0];
  assign dest_high_o   = result_q.dst_addr[127:64];
  assign dest_low_o    = result_q.dst_addr[63:0];
  assign source_port_o = result_q.src_port;
  assign dest_port_o   = result_q.dst_port;

endmodule

`default_nettype wire

[design/ipft_parser.sv]
// Per-packet header state of the IP five-tuple extractor and the result that a
// packet's last byte produces. Depends on ipft_pkg.
`default_nettype none

module ipft_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             first_i,
  input  wire logic             last_i,
  input  wire logic [15:0]      ethertype_i,
  input  wire logic             header_unset_i,
  output ipft_pkg::result_t     result_o
);

  logic [6:0]   offset_q, offset_d;
  ipft_pkg::kind_e kind_q, kind_d;
  logic         nohdr_q, nohdr_d;
  logic [7:0]   vih_q, vih_d;
  logic         frag_q, frag_d;
  logic [7:0]   proto_q, proto_d;
  logic [127:0] src_q, src_d;
  logic [127:0] dst_q, dst_d;
  logic [31:0]  port_q, port_d;
  logic [2:0]   pcount_q, pcount_d;

  logic [6:0]   c_off;
  ipft_pkg::kind_e c_kind;
  logic [7:0]   c_vih;
  logic [5:0]   ihl;
  logic [6:0]   port_start;
  logic         port_en;
  logic         port_hit;
  logic [3:0]   a_idx;
  logic [3:0]   n_ver;
  logic [5:0]   n_ihl;
  logic         ports_ok;

  always_comb begin
    c_off  = first_i ? 7'd0 : offset_q;
    c_vih  = first_i ? 8'd0 : vih_q;
    c_kind = kind_q;
    if (first_i) begin
      case (ethertype_i)
        ipft_pkg::ETHERTYPE_V4: c_kind = ipft_pkg::KIND_V4;
        ipft_pkg::ETHERTYPE_V6: c_kind = ipft_pkg::KIND_V6;
        default:                c_kind = ipft_pkg::KIND_OTHER;
      endcase
    end

    offset_d = c_off;
    kind_d   = c_kind;
    nohdr_d  = first_i ? header_unset_i : nohdr_q;
    vih_d    = c_vih;
    frag_d   = first_i ? 1'b0 : frag_q;
    proto_d  = first_i ? 8'd0 : proto_q;
    src_d    = first_i ? 128'd0 : src_q;
    dst_d    = first_i ? 128'd0 : dst_q;
    port_d   = first_i ? 32'd0 : port_q;
    pcount_d = first_i ? 3'd0 : pcount_q;

    ihl        = {c_vih[3:0], 2'b00};
    port_start = ipft_pkg::V6_HDR_LEN;
    port_en    = 1'b0;
    a_idx      = 4'd0;

    if (c_off < ipft_pkg::OFFSET_MAX) begin
      offset_d = c_off + 7'd1;
      case (c_kind)
        ipft_pkg::KIND_V4: begin
          if (c_off == 7'd0) begin
            vih_d = data_byte_i;
          end else if (c_off == 7'd6) begin
            frag_d = (data_byte_i[4:0] != 5'd0);
          end else if (c_off == 7'd7) begin
            frag_d = frag_d | (data_byte_i != 8'd0);
          end else if (c_off == 7'd9) begin
            proto_d = data_byte_i;
          end else if (c_off >= 7'd12 && c_off < 7'd16) begin
            a_idx = {2'b00, c_off[1:0]};
            src_d[{~a_idx, 3'b111} -: 8] = data_byte_i;
          end else if (c_off >= 7'd16 && c_off < 7'd20) begin
            a_idx = {2'b00, c_off[1:0]};
            dst_d[{~a_idx, 3'b111} -: 8] = data_byte_i;
          end
          port_start = {1'b0, ihl};
          port_en    = (c_off != 7'd0) && ({1'b0, ihl} >= ipft_pkg::V4_HDR_LEN);
        end
        ipft_pkg::KIND_V6: begin
          if (c_off == 7'd0) begin
            vih_d = data_byte_i;
          end else if (c_off == 7'd6) begin
            proto_d = data_byte_i;
          end else if (c_off >= 7'd8 && c_off < 7'd24) begin
            a_idx = 4'(c_off - 7'd8);
            src_d[{~a_idx, 3'b111} -: 8] = data_byte_i;
          end else if (c_off >= 7'd24 && c_off < 7'd40) begin
            a_idx = 4'(c_off - 7'd24);
            dst_d[{~a_idx, 3'b111} -: 8] = data_byte_i;
          end
          port_start = ipft_pkg::V6_HDR_LEN;
          port_en    = 1'b1;
        end
        default: begin
          port_en = 1'b0;
        end
      endcase
    end

    port_hit = port_en && (c_off >= port_start) &&
               (c_off < port_start + 7'd4) && (pcount_d < ipft_pkg::PORT_BYTES);
    if (port_hit) begin
      port_d   = {port_d[23:0], data_byte_i};
      pcount_d = pcount_d + 3'd1;
    end
  end

  always_comb begin
    n_ver = vih_d[7:4];
    n_ihl = {vih_d[3:0], 2'b00};
    result_o = '0;
    result_o.outcome = ipft_pkg::OUT_NO_TUPLE;
    if (nohdr_d) begin
      result_o.outcome = ipft_pkg::OUT_NO_HEADER;
    end else begin
      case (kind_d)
        ipft_pkg::KIND_V4: begin
          if (offset_d < ipft_pkg::V4_HDR_LEN) begin
            result_o.outcome = ipft_pkg::OUT_TRUNCATED;
          end else if (n_ver != ipft_pkg::IP_VER_4 ||
                       {1'b0, n_ihl} < ipft_pkg::V4_HDR_LEN) begin
            result_o.outcome = ipft_pkg::OUT_NO_TUPLE;
          end else begin
            result_o.outcome = ipft_pkg::OUT_TUPLE;
            result_o.family  = ipft_pkg::FAMILY_V4;
          end
        end
        ipft_pkg::KIND_V6: begin
          if (offset_d < ipft_pkg::V6_HDR_LEN) begin
            result_o.outcome = ipft_pkg::OUT_TRUNCATED;
          end else if (n_ver != ipft_pkg::IP_VER_6) begin
            result_o.outcome = ipft_pkg::OUT_NO_TUPLE;
          end else begin
            result_o.outcome = ipft_pkg::OUT_TUPLE;
            result_o.family  = ipft_pkg::FAMILY_V6;
          end
        end
        default: begin
          result_o.outcome = ipft_pkg::OUT_NO_TUPLE;
        end
      endcase
    end

    ports_ok = !(result_o.family == ipft_pkg::FAMILY_V4 && frag_d) &&
               (proto_d == ipft_pkg::PROTO_TCP || proto_d == ipft_pkg::PROTO_UDP) &&
               (pcount_d == ipft_pkg::PORT_BYTES);

    if (result_o.outcome == ipft_pkg::OUT_TUPLE) begin
      result_o.protocol = proto_d;
      result_o.src_addr = src_d;
      result_o.dst_addr = dst_d;
      if (ports_ok) begin
        result_o.src_port = port_d[31:16];
        result_o.dst_port = port_d[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 7'd0;
      kind_q   <= ipft_pkg::KIND_OTHER;
      nohdr_q  <= 1'b0;
      vih_q    <= 8'd0;
      frag_q   <= 1'b0;
      proto_q  <= 8'd0;
      src_q    <= 128'd0;
      dst_q    <= 128'd0;
      port_q   <= 32'd0;
      pcount_q <= 3'd0;
    end else if (take_i) begin
      if (last_i) begin
        offset_q <= 7'd0;
        kind_q   <= ipft_pkg::KIND_OTHER;
        nohdr_q  <= 1'b0;
        vih_q    <= 8'd0;
        frag_q   <= 1'b0;
        proto_q  <= 8'd0;
        src_q    <= 128'd0;
        dst_q    <= 128'd0;
        port_q   <= 32'd0;
        pcount_q <= 3'd0;
      end else begin
        offset_q <= offset_d;
        kind_q   <= kind_d;
        nohdr_q  <= nohdr_d;
        vih_q    <= vih_d;
        frag_q   <= frag_d;
        proto_q  <= proto_d;
        src_q    <= src_d;
        dst_q    <= dst_d;
        port_q   <= port_d;
        pcount_q <= pcount_d;
      end
    end
  end

endmodule

`default_nettype wire

[bench/ipft_checker.sv]
// Checker for the IP five-tuple extractor: watches the byte, result and APB channels,
// predicts the tuple of each packet and compares every result transfer field by field.
// Depends on ipft_pkg for the kinds, outcome codes, header constants and result record.
module ipft_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_of_packet_i,
  input  logic                         last_of_packet_i,
  input  logic [15:0]                  ethertype_i,
  input  logic                         header_unset_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [1:0]                   outcome_i,
  input  logic [2:0]                   family_i,
  input  logic [7:0]                   protocol_i,
  input  logic [63:0]                  source_high_i,
  input  logic [63:0]                  source_low_i,
  input  logic [63:0]                  dest_high_i,
  input  logic [63:0]                  dest_low_i,
  input  logic [15:0]                  source_port_i,
  input  logic [15:0]                  dest_port_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipft_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           mismatches_o,
  output int                           pending_o,
  output int                           compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ipft_pkg::PADDR_W-1:0] ENABLE_ADDR = {ipft_pkg::REG_IDX_ENABLE, 2'b00};

  ipft_pkg::result_t tuple_q[$];
  logic              enable_q;
  logic [6:0]        offset_q;
  ipft_pkg::kind_e   kind_q;
  logic              no_hdr_q;
  logic [7:0]        ver_ihl_q;
  logic              frag_q;
  logic [7:0]        proto_q;
  logic [127:0]      src_q;
  logic [127:0]      dst_q;
  logic [31:0]       port_word_q;
  logic [2:0]        port_cnt_q;

  task automatic clear_packet();
    offset_q    = '0;
    kind_q      = ipft_pkg::KIND_OTHER;
    no_hdr_q    = 1'b0;
    ver_ihl_q   = '0;
    frag_q      = 1'b0;
    proto_q     = '0;
    src_q       = '0;
    dst_q       = '0;
    port_word_q = '0;
    port_cnt_q  = '0;
  endtask

  task automatic take_port(input int o, input int start, input logic [7:0] b);
    if (o >= start && o < start + 4 && port_cnt_q < ipft_pkg::PORT_BYTES) begin
      port_word_q = {port_word_q[23:0], b};
      port_cnt_q++;
    end
  endtask

  task automatic absorb_byte(input int o, input logic [7:0] b);
    int ihl;
    case (kind_q)
      ipft_pkg::KIND_V4: begin
        if (o == 0) ver_ihl_q = b;
        else if (o == 6) frag_q = (b[4:0] != 5'd0);
        else if (o == 7) frag_q = frag_q | (b != 8'd0);
        else if (o == 9) proto_q = b;
        else if (o >= 12 && o < 16) src_q[127 - 8 * (o - 12) -: 8] = b;
        else if (o >= 16 && o < 20) dst_q[127 - 8 * (o - 16) -: 8] = b;
        ihl = int'(ver_ihl_q[3:0]) * 4;
        if (o >= 1 && ihl >= int'(ipft_pkg::V4_HDR_LEN)) take_port(o, ihl, b);
      end
      ipft_pkg::KIND_V6: begin
        if (o == 0) ver_ihl_q = b;
        else if (o == 6) proto_q = b;
        else if (o >= 8 && o < 24) src_q[127 - 8 * (o - 8) -: 8] = b;
        else if (o >= 24 && o < 40) dst_q[127 - 8 * (o - 24) -: 8] = b;
        take_port(o, int'(ipft_pkg::V6_HDR_LEN), b);
      end
      default: ;
    endcase
  endtask

  function automatic ipft_pkg::result_t predict_tuple();
    ipft_pkg::result_t r;
    logic [3:0] ver;
    int ihl;
    r = '0;
    ver = ver_ihl_q[7:4];
    ihl = int'(ver_ihl_q[3:0]) * 4;
    if (no_hdr_q) begin
      r.outcome = ipft_pkg::OUT_NO_HEADER;
    end else if (kind_q == ipft_pkg::KIND_V4) begin
      if (offset_q < ipft_pkg::V4_HDR_LEN) r.outcome = ipft_pkg::OUT_TRUNCATED;
      else if (ver != ipft_pkg::IP_VER_4 || ihl < int'(ipft_pkg::V4_HDR_LEN)) begin
        r.outcome = ipft_pkg::OUT_NO_TUPLE;
      end else begin
        r.outcome = ipft_pkg::OUT_TUPLE;
        r.family = ipft_pkg::FAMILY_V4;
      end
    end else if (kind_q == ipft_pkg::KIND_V6) begin
      if (offset_q < ipft_pkg::V6_HDR_LEN) r.outcome = ipft_pkg::OUT_TRUNCATED;
      else if (ver != ipft_pkg::IP_VER_6) r.outcome = ipft_pkg::OUT_NO_TUPLE;
      else begin
        r.outcome = ipft_pkg::OUT_TUPLE;
        r.family = ipft_pkg::FAMILY_V6;
      end
    end else begin
      r.outcome = ipft_pkg::OUT_NO_TUPLE;
    end
    if (r.outcome == ipft_pkg::OUT_TUPLE) begin
      r.protocol = proto_q;
      r.src_addr = src_q;
      r.dst_addr = dst_q;
      if (!(r.family == ipft_pkg::FAMILY_V4 && frag_q) &&
          (proto_q == ipft_pkg::PROTO_TCP || proto_q == ipft_pkg::PROTO_UDP) &&
          port_cnt_q == ipft_pkg::PORT_BYTES) begin
        r.src_port = port_word_q[31:16];
        r.dst_port = port_word_q[15:0];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches_o++;
    end
  endtask

  initial begin
    mismatches_o = 0;
    pending_o = 0;
    compared_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ipft_pkg::result_t exp;
    if (!rst_ni) begin
      enable_q = 1'b1;
      clear_packet();
      tuple_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tuple_q.size() == 0) begin
          $error("result transfer with no packet awaiting one");
          mismatches_o++;
        end else begin
          exp = tuple_q.pop_front();
          check_field("outcome", 64'(exp.outcome), 64'(outcome_i));
          check_field("family", 64'(exp.family), 64'(family_i));
          check_field("protocol", 64'(exp.protocol), 64'(protocol_i));
          check_field("source_high", exp.src_addr[127:64], source_high_i);
          check_field("source_low", exp.src_addr[63:0], source_low_i);
          check_field("dest_high", exp.dst_addr[127:64], dest_high_i);
          check_field("dest_low", exp.dst_addr[63:0], dest_low_i);
          check_field("source_port", 64'(exp.src_port), 64'(source_port_i));
          check_field("dest_port", 64'(exp.dst_port), 64'(dest_port_i));
          compared_o++;
        end
      end
      if (psel && penable && pready && paddr == ENABLE_ADDR) begin
        if (pwrite) enable_q = pwdata[0];
        else check_field("enable", 64'(enable_q), 64'(prdata[0]));
      end
      if (in_valid_i && in_ready_i) begin
        if (first_of_packet_i) begin
          clear_packet();
          no_hdr_q = header_unset_i;
          if (ethertype_i == ipft_pkg::ETHERTYPE_V4) kind_q = ipft_pkg::KIND_V4;
          else if (ethertype_i == ipft_pkg::ETHERTYPE_V6) kind_q = ipft_pkg::KIND_V6;
          else kind_q = ipft_pkg::KIND_OTHER;
        end
        if (offset_q < ipft_pkg::OFFSET_MAX) begin
          absorb_byte(int'(offset_q), data_byte_i);
          offset_q++;
        end
        if (last_of_packet_i) begin
          if (enable_q) tuple_q.push_back(predict_tuple());
          clear_packet();
        end
      end
    end
    pending_o = tuple_q.size();
  end

endmodule

[bench/testbench.sv]
// Top of the IP five-tuple extractor testbench: clock, reset, packet stimulus,
// result back-pressure and APB register traffic, and the final verdict.
// Depends on ipft_pkg, ip_five_tuple_extractor_top and ipft_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ipft_pkg::PADDR_W-1:0] ENABLE_ADDR = {ipft_pkg::REG_IDX_ENABLE, 2'b00};
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_ready_o;
  logic [7:0] data_byte_i;
  logic first_of_packet_i, last_of_packet_i;
  logic [15:0] ethertype_i;
  logic header_unset_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] outcome_o;
  logic [2:0] family_o;
  logic [7:0] protocol_o;
  logic [63:0] source_high_o, source_low_o, dest_high_o, dest_low_o;
  logic [15:0] source_port_o, dest_port_o;
  logic psel, penable, pwrite, pready;
  logic [ipft_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  int mismatches, pending, compared;
  int bytes_sent = 0;
  int packets_sent = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  logic [7:0] pkt[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ip_five_tuple_extractor_top uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .data_byte_i, .first_of_packet_i, .last_of_packet_i,
    .ethertype_i, .header_unset_i,
    .out_valid_o, .out_ready_i, .outcome_o, .family_o, .protocol_o,
    .source_high_o, .source_low_o, .dest_high_o, .dest_low_o, .source_port_o, .dest_port_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ipft_checker tuple_watch (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i, .first_of_packet_i,
    .last_of_packet_i, .ethertype_i, .header_unset_i,
    .out_valid_i(out_valid_o), .out_ready_i, .outcome_i(outcome_o), .family_i(family_o),
    .protocol_i(protocol_o), .source_high_i(source_high_o), .source_low_i(source_low_o),
    .dest_high_i(dest_high_o), .dest_low_i(dest_low_o), .source_port_i(source_port_o),
    .dest_port_i(dest_port_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches_o(mismatches), .pending_o(pending), .compared_o(compared)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int sender_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic first, input logic last,
                          input logic [15:0] et, input logic unset);
    int gap;
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_of_packet_i <= first;
    last_of_packet_i <= last;
    ethertype_i <= et;
    header_unset_i <= unset;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_packet(input logic [15:0] et, input logic unset, input bit with_first,
                             input bit with_last);
    for (int i = 0; i < pkt.size(); i++) begin
      put_byte(pkt[i], with_first && i == 0, with_last && i == pkt.size() - 1,
               (i == 0) ? et : 16'($urandom), (i == 0) ? unset : 1'($urandom));
    end
    packets_sent++;
  endtask

  task automatic fill_random(input int len);
    pkt.delete();
    repeat (len) pkt.push_back(8'($urandom));
  endtask

  task automatic make_v4(input int len, input logic [3:0] ver, input logic [3:0] ihl,
                         input logic [7:0] proto, input bit frag);
    fill_random(len);
    pkt[0] = {ver, ihl};
    if (len > 7) begin
      pkt[6] = pkt[6] & 8'hE0;
      pkt[7] = 8'h00;
      if (frag) begin
        if ($urandom_range(0, 1)) pkt[6] = pkt[6] | 8'($urandom_range(1, 31));
        else pkt[7] = 8'($urandom_range(1, 255));
      end
    end
    if (len > 9) pkt[9] = proto;
  endtask

  task automatic make_v6(input int len, input logic [3:0] ver, input logic [7:0] next_hdr);
    fill_random(len);
    pkt[0] = {ver, 4'($urandom)};
    if (len > 6) pkt[6] = next_hdr;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ENABLE_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_enable(input logic en);
    reg_access(1'b1, {31'($urandom), en});
    reg_access(1'b0, 32'd0);
  endtask

  task automatic random_packet();
    int pick, ihl;
    logic [7:0] proto;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: proto = ipft_pkg::PROTO_TCP;
      1: proto = ipft_pkg::PROTO_UDP;
      2: proto = 8'($urandom);
      default: proto = ipft_pkg::PROTO_TCP;
    endcase
    steady = ($urandom_range(0, 5) == 0);
    if (pick < 40) begin
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      make_v4(ihl * 4 + $urandom_range(0, 8), ipft_pkg::IP_VER_4, 4'(ihl), proto,
              $urandom_range(0, 7) == 0);
      send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    end else if (pick < 70) begin
      make_v6(40 + $urandom_range(0, 8), ipft_pkg::IP_VER_6, proto);
      send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
    end else if (pick < 76) begin
      if ($urandom_range(0, 1)) begin
        make_v4($urandom_range(1, 19), ipft_pkg::IP_VER_4, 4'd5, proto, 1'b0);
        send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
      end else begin
        make_v6($urandom_range(1, 39), ipft_pkg::IP_VER_6, proto);
        send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
      end
    end else if (pick < 81) begin
      if ($urandom_range(0, 1)) begin
        make_v4($urandom_range(20, 30), 4'($urandom), 4'($urandom), proto, 1'b0);
        send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
      end else begin
        make_v6($urandom_range(40, 46), 4'($urandom), proto);
        send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
      end
    end else if (pick < 86) begin
      fill_random($urandom_range(1, 30));
      send_packet(16'($urandom), 1'b0, 1'b1, 1'b1);
    end else if (pick < 89) begin
      make_v4(24, ipft_pkg::IP_VER_4, 4'd5, proto, 1'b0);
      send_packet($urandom_range(0, 1) ? ipft_pkg::ETHERTYPE_V4 : ipft_pkg::ETHERTYPE_V6,
                  1'b1, 1'b1, 1'b1);
    end else if (pick < 92) begin
      fill_random($urandom_range(1, 10));
      send_packet(16'($urandom), 1'($urandom), 1'b0, 1'b1);
    end else if (pick < 96) begin
      make_v6($urandom_range(1, 30), ipft_pkg::IP_VER_6, proto);
      send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b0);
      make_v4(24, ipft_pkg::IP_VER_4, 4'd5, proto, 1'b0);
      send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    end else if (pick < 98) begin
      make_v4($urandom_range(120, 140), ipft_pkg::IP_VER_4, 4'd5, proto, 1'b0);
      send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    end else begin
      fill_random($urandom_range(1, 5));
      send_packet(16'($urandom), 1'($urandom), 1'($urandom), 1'b1);
    end
  endtask

  task automatic random_phase(input int byte_goal);
    while (bytes_sent < byte_goal) begin
      random_packet();
      if ($urandom_range(0, 39) == 0) settle();
    end
  endtask

  initial begin
    int r, span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (steady) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready_i <= 1'b1;
          span = $urandom_range(1, 12);
        end else if (r < 92) begin
          out_ready_i <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          span = $urandom_range(10, 40);
        end
        repeat (span) @(negedge clk_i);
      end
    end
  end

  initial begin
    in_valid_i = 1'b0;
    data_byte_i = '0;
    first_of_packet_i = 1'b0;
    last_of_packet_i = 1'b0;
    ethertype_i = '0;
    header_unset_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Bytes ahead of any first byte form a packet of unknown kind.
    fill_random(3);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b0, 1'b1);
    fill_random(1);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b1, 1'b1, 1'b1);
    make_v4(19, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(24, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    for (int i = 12; i < 16; i++) pkt[i] = 8'hFF;
    for (int i = 16; i < 20; i++) pkt[i] = 8'h00;
    for (int i = 20; i < 24; i++) pkt[i] = 8'hFF;
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(64, ipft_pkg::IP_VER_4, 4'd15, ipft_pkg::PROTO_UDP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(24, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_UDP, 1'b1);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(24, ipft_pkg::IP_VER_4, 4'd4, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(24, ipft_pkg::IP_VER_6, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v4(22, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    make_v6(44, ipft_pkg::IP_VER_6, ipft_pkg::PROTO_TCP);
    for (int i = 8; i < 24; i++) pkt[i] = 8'hFF;
    for (int i = 24; i < 40; i++) pkt[i] = 8'h00;
    for (int i = 40; i < 44; i++) pkt[i] = 8'hFF;
    send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
    make_v6(39, ipft_pkg::IP_VER_6, ipft_pkg::PROTO_UDP);
    send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
    make_v6(40, ipft_pkg::IP_VER_4, ipft_pkg::PROTO_UDP);
    send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
    fill_random(20);
    send_packet(16'hFFFF, 1'b0, 1'b1, 1'b1);
    fill_random(2);
    send_packet(16'h0000, 1'b1, 1'b1, 1'b1);
    make_v4(10, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b0);
    make_v6(41, ipft_pkg::IP_VER_6, ipft_pkg::PROTO_UDP);
    send_packet(ipft_pkg::ETHERTYPE_V6, 1'b0, 1'b1, 1'b1);
    make_v4(130, ipft_pkg::IP_VER_4, 4'd5, ipft_pkg::PROTO_TCP, 1'b0);
    send_packet(ipft_pkg::ETHERTYPE_V4, 1'b0, 1'b1, 1'b1);
    settle();

    set_enable(1'b1);
    hold_request = 1'b1;
    repeat (6) random_packet();
    random_phase(bytes_sent + 350);
    settle();

    set_enable(1'b0);
    random_phase(bytes_sent + 150);
    settle();

    set_enable(1'b1);
    random_phase(bytes_sent + 300);
    settle();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d packets in %0d byte transfers; %0d tuple results compared.",
             packets_sent, bytes_sent, compared);
    $display("Enable was on and off, and results were held back for %0d cycles once.",
             HOLD_CYCLES);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
